[src/periodic_task_tick_table_macros.svh]
// ----------------------------------------------------------------------------
// Periodic task tick table - assertion macros
// Shared concurrent assertion forms, clocked on a rising edge and held off in
// reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_TABLE_MACROS_SVH
`define PERIODIC_TASK_TICK_TABLE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic task tick table - package
// Shared constants, table entry layout, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptt_pkg;

	localparam int MAX_TASKS_DEF = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int NRW           = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_FIRED     = 2'd3;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] period;
		logic [15:0] remaining;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_RM_RD,
		ST_RM_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_TK_RD,
		ST_TK_UPD,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		WR_ADD,
		WR_SHIFT,
		WR_TICK
	} wr_kind_t;

	typedef enum logic [2:0] {
		RES_OK,
		RES_FULL,
		RES_NOT_FOUND,
		RES_PEND,
		RES_FINAL
	} res_kind_t;

	typedef struct packed {
		logic      latch;
		logic      idx_inc;
		logic      rd_en;
		logic      rd_next;
		logic      wr_en;
		wr_kind_t  wr_kind;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      rep_inc;
		logic      push;
		res_kind_t push_kind;
	} cmd_t;

	typedef struct packed {
		logic room;
		logic idx_lt_cnt;
		logic nxt_lt_cnt;
		logic id_match;
		logic fire;
		logic rep_room;
		logic have_pend;
		logic out_space;
	} sts_t;

endpackage

[src/periodic_task_tick_table.sv]
// ----------------------------------------------------------------------------
// Periodic task tick table - top level
// Compacted table of periodic tasks: add, remove by id, and timer tick that
// reports up to MAX_RESULTS tasks whose count runs out.
//
//   channel  dir  tdata fields (low bit up)                    side bits
//   s_       in   opcode[1:0] task_id[9:2] period[25:10]        -
//                 first_delay[41:26], zero fill to 48
//   m_       out  status[1:0] fired_id[9:2], zero fill to 16    tlast = last
//
// One item at a time; table reads are registered. Add appends if there is
// room; remove compares entries to the id, then shifts later entries down;
// tick rewrites each entry decremented or reloaded from its period. Reset
// clears the counts, walk index and output valid, not the table.
// A stalled result stalls the walk only when the next result is ready to go.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_task_tick_table
	import ptt_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // opcode, task_id, period, first_delay
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // status, fired_id
	output logic        m_tlast
);

	`include "periodic_task_tick_table_macros.svh"

	cmd_t       cmd;
	sts_t       sts;
	logic [1:0] res_status;
	logic [7:0] res_id;

	ptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tdata[1:0]),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptt_dp #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_id      (s_tdata[9:2]),
		.in_period  (s_tdata[25:10]),
		.in_first   (s_tdata[41:26]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (res_status),
		.out_id     (res_id),
		.out_last   (m_tlast)
	);

	assign m_tdata = {6'd0, res_id, res_status};

	`PTT_ASSERT_NOW(a_push_space, clk, arst_n, cmd.push, sts.out_space, "result pushed over a waiting one")
	`PTT_ASSERT_NOW(a_add_room, clk, arst_n, cmd.cnt_inc, sts.room && cmd.wr_en, "entry added to a full table")
	`PTT_ASSERT_NOW(a_accept_quiet, clk, arst_n, s_tvalid && s_tready, !cmd.wr_en && !cmd.push, "table busy at accept")
	`PTT_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "second item taken before the first finished")

endmodule

[src/ptt_ctrl.sv]
// ----------------------------------------------------------------------------
// Periodic task tick table - controller
// Sequences add, remove (search then shift down) and tick (walk and reload)
// over the entry table, with reads and writes in separate states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptt_ctrl
	import ptt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic   rec;
	logic   stall;

	// a fire is recorded while the report budget lasts; the previous one goes out
	assign rec   = sts.fire & sts.rep_room;
	assign stall = rec & sts.have_pend & ~sts.out_space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_op)
						OP_ADD:    state_d = ST_ADD;
						OP_REMOVE: state_d = ST_RM_RD;
						OP_TICK:   state_d = ST_TK_RD;
						default:   state_d = ST_FINISH;
					endcase
				end
			end
			ST_ADD: begin
				if (sts.out_space) state_d = ST_IDLE;
			end
			ST_RM_RD: begin
				if (sts.idx_lt_cnt)     state_d = ST_RM_CMP;
				else if (sts.out_space) state_d = ST_IDLE;
			end
			ST_RM_CMP: begin
				state_d = sts.id_match ? ST_SH_RD : ST_RM_RD;
			end
			ST_SH_RD: begin
				if (sts.nxt_lt_cnt)     state_d = ST_SH_WR;
				else if (sts.out_space) state_d = ST_IDLE;
			end
			ST_SH_WR: state_d = ST_SH_RD;
			ST_TK_RD: begin
				state_d = sts.idx_lt_cnt ? ST_TK_UPD : ST_FINISH;
			end
			ST_TK_UPD: begin
				if (!stall) state_d = ST_TK_RD;
			end
			ST_FINISH: begin
				if (sts.out_space) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.wr_kind   = WR_ADD;
		cmd.push_kind = RES_OK;
		in_ready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			ST_ADD: begin
				if (sts.out_space) begin
					cmd.push      = 1'b1;
					cmd.push_kind = sts.room ? RES_OK : RES_FULL;
					cmd.wr_en     = sts.room;
					cmd.wr_kind   = WR_ADD;
					cmd.cnt_inc   = sts.room;
				end
			end
			ST_RM_RD: begin
				if (sts.idx_lt_cnt) begin
					cmd.rd_en = 1'b1;
				end else if (sts.out_space) begin
					cmd.push      = 1'b1;
					cmd.push_kind = RES_NOT_FOUND;
				end
			end
			ST_RM_CMP: begin
				cmd.idx_inc = ~sts.id_match;
			end
			ST_SH_RD: begin
				if (sts.nxt_lt_cnt) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
				end else if (sts.out_space) begin
					cmd.push      = 1'b1;
					cmd.push_kind = RES_OK;
					cmd.cnt_dec   = 1'b1;
				end
			end
			ST_SH_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_kind = WR_SHIFT;
				cmd.idx_inc = 1'b1;
			end
			ST_TK_RD: begin
				cmd.rd_en = sts.idx_lt_cnt;
			end
			ST_TK_UPD: begin
				if (!stall) begin
					cmd.wr_en     = 1'b1;
					cmd.wr_kind   = WR_TICK;
					cmd.idx_inc   = 1'b1;
					cmd.rep_inc   = rec;
					cmd.push      = rec & sts.have_pend;
					cmd.push_kind = RES_PEND;
				end
			end
			ST_FINISH: begin
				if (sts.out_space) begin
					cmd.push      = 1'b1;
					cmd.push_kind = RES_FINAL;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[src/ptt_dp.sv]
// ----------------------------------------------------------------------------
// Periodic task tick table - datapath
// Entry table memory with registered read, fill count, walk index, report
// count with the held-back fire id, and the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptt_dp
	import ptt_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [7:0]  in_id,
	input  logic [15:0] in_period,
	input  logic [15:0] in_first,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_status,
	output logic [7:0]  out_id,
	output logic        out_last
);

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	entry_t          mem_q [MAX_TASKS];
	entry_t          rd_q;
	entry_t          wr_data;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic [7:0]      id_q;
	logic [15:0]     per_q;
	logic [15:0]     first_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic [CW:0]     idx_nxt;
	logic [NRW-1:0]  nrep_q;
	logic [7:0]      pend_id_q;
	logic [15:0]     dec;
	logic            out_valid_q;
	logic [1:0]      out_status_q;
	logic [7:0]      out_id_q;
	logic            out_last_q;

	assign idx_nxt = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
	assign rd_addr = cmd.rd_next ? idx_nxt[AW-1:0] : idx_q[AW-1:0];
	assign wr_addr = (cmd.wr_kind == WR_ADD) ? count_q[AW-1:0] : idx_q[AW-1:0];
	assign dec     = rd_q.remaining - 16'd1;

	always_comb begin
		case (cmd.wr_kind)
			WR_ADD:   wr_data = '{id: id_q, period: per_q, remaining: first_q};
			WR_SHIFT: wr_data = rd_q;
			WR_TICK: begin
				wr_data           = rd_q;
				wr_data.remaining = (dec == 16'd0) ? rd_q.period : dec;
			end
			default:  wr_data = rd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			id_q    <= in_id;
			per_q   <= in_period;
			first_q <= in_first;
		end
		if (cmd.rep_inc) begin
			pend_id_q <= rd_q.id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			nrep_q  <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - {{(CW-1){1'b0}}, 1'b1};
			end
			if (cmd.latch) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_nxt[CW-1:0];
			end
			if (cmd.latch) begin
				nrep_q <= '0;
			end else if (cmd.rep_inc) begin
				nrep_q <= nrep_q + {{(NRW-1){1'b0}}, 1'b1};
			end
		end
	end

	// hold a result until taken; a new one may load in the cycle it leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			case (cmd.push_kind)
				RES_OK: begin
					out_status_q <= STAT_OK;
					out_id_q     <= 8'd0;
					out_last_q   <= 1'b1;
				end
				RES_FULL: begin
					out_status_q <= STAT_FULL;
					out_id_q     <= 8'd0;
					out_last_q   <= 1'b1;
				end
				RES_NOT_FOUND: begin
					out_status_q <= STAT_NOT_FOUND;
					out_id_q     <= 8'd0;
					out_last_q   <= 1'b1;
				end
				RES_PEND: begin
					out_status_q <= STAT_FIRED;
					out_id_q     <= pend_id_q;
					out_last_q   <= 1'b0;
				end
				RES_FINAL: begin
					out_status_q <= (nrep_q != '0) ? STAT_FIRED : STAT_OK;
					out_id_q     <= (nrep_q != '0) ? pend_id_q : 8'd0;
					out_last_q   <= 1'b1;
				end
				default: begin
					out_status_q <= STAT_OK;
					out_id_q     <= 8'd0;
					out_last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign sts.room       = count_q < CW'(MAX_TASKS);
	assign sts.idx_lt_cnt = idx_q < count_q;
	assign sts.nxt_lt_cnt = idx_nxt < {1'b0, count_q};
	assign sts.id_match   = rd_q.id == id_q;
	assign sts.fire       = dec == 16'd0;
	assign sts.rep_room   = nrep_q < NRW'(MAX_RESULTS);
	assign sts.have_pend  = nrep_q != '0;
	assign sts.out_space  = ~out_valid_q | out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_id     = out_id_q;
	assign out_last   = out_last_q;

endmodule
